@@ hdl/vfl_pkg.sv @@
// Shared constants, types and helpers for the voxel face light / occlusion block.
// Holds the corner-to-neighbour table and the occlusion function.
// No dependencies.
package vfl_pkg;

  localparam int unsigned LIGHT_BITS_DEF = 4;
  localparam int unsigned NUM_CELLS      = 8;
  localparam int unsigned NUM_CORNERS    = 4;
  localparam int unsigned CELLS_PER_CRN  = 3;
  localparam int unsigned OCC_W          = 3;

  typedef logic [$clog2(NUM_CELLS)-1:0] cell_idx_t;
  typedef logic [OCC_W-1:0]             occ_t;

  localparam occ_t OCC_OPEN       = 3'd4;  // no opaque cell around the corner
  localparam occ_t OCC_BOTH_EDGES = 3'd1;  // both edges opaque, diagonal hidden

  // Per corner: edge a, edge b, diagonal.
  localparam cell_idx_t CORNER_CELLS [NUM_CORNERS][CELLS_PER_CRN] = '{
    '{3'd1, 3'd3, 3'd0},
    '{3'd3, 3'd6, 3'd5},
    '{3'd4, 3'd6, 3'd7},
    '{3'd1, 3'd4, 3'd2}
  };

  function automatic occ_t occ_level(logic edge_a, logic edge_b, logic diag);
    occ_t cnt;
    cnt = occ_t'(edge_a) + occ_t'(edge_b) + occ_t'(diag);
    if (edge_a && edge_b) begin
      occ_level = OCC_BOTH_EDGES;
    end else begin
      occ_level = OCC_OPEN - cnt;
    end
  endfunction

endpackage

@@ hdl/vfl_intf.sv @@
// Channel interfaces: face descriptor in, corner light / occlusion result out.
// Depends on vfl_pkg.
interface vfl_face_if
  import vfl_pkg::*;
#(
  parameter int unsigned LIGHT_BITS = LIGHT_BITS_DEF
);
  logic                            valid;
  logic                            ready;
  logic [LIGHT_BITS-1:0]           center_block_light;
  logic [LIGHT_BITS-1:0]           center_sky_light;
  logic [NUM_CELLS-1:0]            neighbour_opaque_mask;
  logic [NUM_CELLS*LIGHT_BITS-1:0] neighbour_block_lights;
  logic [NUM_CELLS*LIGHT_BITS-1:0] neighbour_sky_lights;

  modport source (
    output valid, center_block_light, center_sky_light, neighbour_opaque_mask,
           neighbour_block_lights, neighbour_sky_lights,
    input  ready
  );
  modport sink (
    input  valid, center_block_light, center_sky_light, neighbour_opaque_mask,
           neighbour_block_lights, neighbour_sky_lights,
    output ready
  );
endinterface

interface vfl_vertex_if
  import vfl_pkg::*;
#(
  parameter int unsigned LIGHT_BITS = LIGHT_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  occ_t                  occlusion_corner0;
  occ_t                  occlusion_corner1;
  occ_t                  occlusion_corner2;
  occ_t                  occlusion_corner3;
  logic [LIGHT_BITS+1:0] block_sum_corner0;
  logic [LIGHT_BITS+1:0] block_sum_corner1;
  logic [LIGHT_BITS+1:0] block_sum_corner2;
  logic [LIGHT_BITS+1:0] block_sum_corner3;
  logic [LIGHT_BITS+1:0] sky_sum_corner0;
  logic [LIGHT_BITS+1:0] sky_sum_corner1;
  logic [LIGHT_BITS+1:0] sky_sum_corner2;
  logic [LIGHT_BITS+1:0] sky_sum_corner3;

  modport source (
    output valid, occlusion_corner0, occlusion_corner1, occlusion_corner2,
           occlusion_corner3, block_sum_corner0, block_sum_corner1,
           block_sum_corner2, block_sum_corner3, sky_sum_corner0,
           sky_sum_corner1, sky_sum_corner2, sky_sum_corner3,
    input  ready
  );
  modport sink (
    input  valid, occlusion_corner0, occlusion_corner1, occlusion_corner2,
           occlusion_corner3, block_sum_corner0, block_sum_corner1,
           block_sum_corner2, block_sum_corner3, sky_sum_corner0,
           sky_sum_corner1, sky_sum_corner2, sky_sum_corner3,
    output ready
  );
endinterface

@@ hdl/vfl_lane.sv @@
// One corner lane: occlusion level plus smoothed block and sky light sums.
// Depends on vfl_pkg (occ_level).
module vfl_lane
  import vfl_pkg::*;
#(
  parameter int unsigned LIGHT_BITS = LIGHT_BITS_DEF
) (
  input  logic [CELLS_PER_CRN-1:0]            opaque_i,   // edge a, edge b, diagonal
  input  logic [LIGHT_BITS-1:0]               ctr_block_i,
  input  logic [LIGHT_BITS-1:0]               ctr_sky_i,
  input  logic [CELLS_PER_CRN*LIGHT_BITS-1:0] nbr_block_i,
  input  logic [CELLS_PER_CRN*LIGHT_BITS-1:0] nbr_sky_i,
  output occ_t                                occlusion_o,
  output logic [LIGHT_BITS+1:0]               block_sum_o,
  output logic [LIGHT_BITS+1:0]               sky_sum_o
);

  localparam int unsigned SUM_W = LIGHT_BITS + 2;

  // Floor is the least of centre and nonzero neighbours. With no zero present
  // the floor is the overall minimum, so lifting changes nothing there.
  function automatic logic [SUM_W-1:0] smooth(
    logic [LIGHT_BITS-1:0]               ctr,
    logic [CELLS_PER_CRN*LIGHT_BITS-1:0] nbr
  );
    logic [LIGHT_BITS-1:0] flr;
    logic [LIGHT_BITS-1:0] v;
    logic [SUM_W-1:0]      acc;
    flr = ctr;
    for (int i = 0; i < CELLS_PER_CRN; i++) begin
      v = nbr[i*LIGHT_BITS +: LIGHT_BITS];
      if (v != '0 && v < flr) begin
        flr = v;
      end
    end
    acc = SUM_W'(ctr);
    for (int i = 0; i < CELLS_PER_CRN; i++) begin
      v = nbr[i*LIGHT_BITS +: LIGHT_BITS];
      acc = acc + SUM_W'((v < flr) ? flr : v);
    end
    smooth = acc;
  endfunction

  assign occlusion_o = occ_level(opaque_i[0], opaque_i[1], opaque_i[2]);
  assign block_sum_o = smooth(ctr_block_i, nbr_block_i);
  assign sky_sum_o   = smooth(ctr_sky_i, nbr_sky_i);

endmodule

@@ hdl/vfl_merge.sv @@
// Result stage: collects the lane outputs into one word behind a two-entry
// output register (main plus skid), so one more word is taken under stall.
// Depends on vfl_pkg for the default of DATA_W (OCC_W, LIGHT_BITS_DEF).
module vfl_merge
  import vfl_pkg::*;
#(
  parameter int unsigned DATA_W = 4 * (OCC_W + 2 * (LIGHT_BITS_DEF + 2))
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  logic [DATA_W-1:0] data_i,
  output logic              valid_o,
  input  logic              ready_i,
  output logic [DATA_W-1:0] data_o
);

  logic              main_vld_q, main_vld_d;
  logic              skid_vld_q, skid_vld_d;
  logic [DATA_W-1:0] main_q, main_d;
  logic [DATA_W-1:0] skid_q, skid_d;
  logic              in_xfer, out_xfer;

  assign ready_o  = ~skid_vld_q;
  assign in_xfer  = valid_i & ready_o;
  assign out_xfer = main_vld_q & ready_i;
  assign valid_o  = main_vld_q;
  assign data_o   = main_q;

  always_comb begin
    main_vld_d = main_vld_q;
    skid_vld_d = skid_vld_q;
    main_d     = main_q;
    skid_d     = skid_q;
    if (out_xfer) begin
      if (skid_vld_q) begin
        // advance the skid entry; input is held off while it is full
        main_d     = skid_q;
        skid_vld_d = 1'b0;
      end else if (in_xfer) begin
        main_d = data_i;
      end else begin
        main_vld_d = 1'b0;
      end
    end else if (in_xfer) begin
      if (main_vld_q) begin
        skid_d     = data_i;
        skid_vld_d = 1'b1;
      end else begin
        main_d     = data_i;
        main_vld_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_vld_q <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      main_vld_q <= main_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

endmodule

@@ hdl/voxel_face_vertex_light_ao.sv @@
// Per-face corner ambient occlusion and smoothed block/sky light. Four corner
// lanes evaluate one face combinationally and a result stage registers the
// twelve outputs, so a face is taken every clock unless the input stalls; its
// result goes to the output register, or to the skid entry while it is occupied.
// The result stage holds two results (output register plus skid), so a new face
// is still taken while one finished result waits; the input stalls only when
// both entries are full. Rate: one face per cycle unless stalled. No reset
// sweep; ready from reset. Depends on vfl_pkg, vfl_intf, vfl_lane, vfl_merge.
module voxel_face_vertex_light_ao
  import vfl_pkg::*;
#(
  parameter int unsigned LIGHT_BITS = LIGHT_BITS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  vfl_face_if.sink     face_i,
  vfl_vertex_if.source vtx_o
);

  localparam int unsigned SUM_W  = LIGHT_BITS + 2;
  localparam int unsigned LANE_W = OCC_W + 2 * SUM_W;
  localparam int unsigned DATA_W = NUM_CORNERS * LANE_W;

  occ_t             lane_occ [NUM_CORNERS];
  logic [SUM_W-1:0] lane_blk [NUM_CORNERS];
  logic [SUM_W-1:0] lane_sky [NUM_CORNERS];
  logic [DATA_W-1:0] lane_word;
  logic [DATA_W-1:0] res_word;
  occ_t             res_occ  [NUM_CORNERS];
  logic [SUM_W-1:0] res_blk  [NUM_CORNERS];
  logic [SUM_W-1:0] res_sky  [NUM_CORNERS];

  for (genvar k = 0; k < NUM_CORNERS; k++) begin : g_lane
    logic [CELLS_PER_CRN-1:0]            opq;
    logic [CELLS_PER_CRN*LIGHT_BITS-1:0] nb;
    logic [CELLS_PER_CRN*LIGHT_BITS-1:0] ns;

    for (genvar c = 0; c < CELLS_PER_CRN; c++) begin : g_cell
      assign opq[c] = face_i.neighbour_opaque_mask[CORNER_CELLS[k][c]];
      assign nb[c*LIGHT_BITS +: LIGHT_BITS] =
        face_i.neighbour_block_lights[CORNER_CELLS[k][c]*LIGHT_BITS +: LIGHT_BITS];
      assign ns[c*LIGHT_BITS +: LIGHT_BITS] =
        face_i.neighbour_sky_lights[CORNER_CELLS[k][c]*LIGHT_BITS +: LIGHT_BITS];
    end

    vfl_lane #(
      .LIGHT_BITS (LIGHT_BITS)
    ) u_lane (
      .opaque_i    (opq),
      .ctr_block_i (face_i.center_block_light),
      .ctr_sky_i   (face_i.center_sky_light),
      .nbr_block_i (nb),
      .nbr_sky_i   (ns),
      .occlusion_o (lane_occ[k]),
      .block_sum_o (lane_blk[k]),
      .sky_sum_o   (lane_sky[k])
    );

    assign lane_word[k*LANE_W +: LANE_W] = {lane_occ[k], lane_blk[k], lane_sky[k]};
    assign {res_occ[k], res_blk[k], res_sky[k]} = res_word[k*LANE_W +: LANE_W];
  end

  vfl_merge #(
    .DATA_W (DATA_W)
  ) u_merge (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (face_i.valid),
    .ready_o (face_i.ready),
    .data_i  (lane_word),
    .valid_o (vtx_o.valid),
    .ready_i (vtx_o.ready),
    .data_o  (res_word)
  );

  assign vtx_o.occlusion_corner0 = res_occ[0];
  assign vtx_o.occlusion_corner1 = res_occ[1];
  assign vtx_o.occlusion_corner2 = res_occ[2];
  assign vtx_o.occlusion_corner3 = res_occ[3];
  assign vtx_o.block_sum_corner0 = res_blk[0];
  assign vtx_o.block_sum_corner1 = res_blk[1];
  assign vtx_o.block_sum_corner2 = res_blk[2];
  assign vtx_o.block_sum_corner3 = res_blk[3];
  assign vtx_o.sky_sum_corner0   = res_sky[0];
  assign vtx_o.sky_sum_corner1   = res_sky[1];
  assign vtx_o.sky_sum_corner2   = res_sky[2];
  assign vtx_o.sky_sum_corner3   = res_sky[3];

  // A stalled input means both result entries are occupied.
  a_stall_means_full: assert property (
    @(posedge clk_i) disable iff (!rst_ni) !face_i.ready |-> vtx_o.valid
  ) else $error("input stalled while result register empty");

  // A transferred face always leaves a result visible in the next cycle.
  a_xfer_gives_result: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
      (face_i.valid && face_i.ready) |=> vtx_o.valid
  ) else $error("accepted face produced no result");

  // Occlusion levels of corners 0 and 2 stay between fully shadowed and open.
  a_occ_range: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
      vtx_o.valid |-> (res_occ[0] >= OCC_BOTH_EDGES && res_occ[0] <= OCC_OPEN &&
                       res_occ[2] >= OCC_BOTH_EDGES && res_occ[2] <= OCC_OPEN)
  ) else $error("occlusion level out of range");

endmodule

@@ verif/vfl_face_light_checker.sv @@
// Checker for voxel_face_vertex_light_ao: predicts corner occlusion and smoothed light
// for every face transfer and compares each result transfer against the oldest prediction.
// Depends on vfl_pkg and the channel interfaces in vfl_intf.
module vfl_face_light_checker
  import vfl_pkg::*;
#(
  parameter int unsigned LB = LIGHT_BITS_DEF
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  vfl_face_if   face_i,
  vfl_vertex_if vtx_i,
  output int    fail_cnt_o,
  output int    pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SUM_W = LB + 2;

  typedef logic [SUM_W-1:0] light_sum_t;
  typedef logic [LB-1:0]    light_t;

  typedef struct packed {
    occ_t       [NUM_CORNERS-1:0] occ;
    light_sum_t [NUM_CORNERS-1:0] blk;
    light_sum_t [NUM_CORNERS-1:0] sky;
  } corner_light_t;

  // Per corner: edge a, edge b, diagonal.
  localparam int unsigned CORNER_NBR [4][3] = '{
    '{1, 3, 0},
    '{3, 6, 5},
    '{4, 6, 7},
    '{1, 4, 2}
  };

  corner_light_t corner_light_q [$];
  int            errors = 0;

  function automatic light_sum_t smoothed_sum(light_t ctr, light_t e1, light_t e2, light_t dg);
    light_t     lvl [4];
    light_t     flr;
    light_sum_t acc;
    int         i;
    lvl[0] = ctr;
    lvl[1] = e1;
    lvl[2] = e2;
    lvl[3] = dg;
    // Floor skips dark neighbours but never the center. With no dark value the
    // floor is the minimum, so lifting changes nothing.
    flr = ctr;
    for (i = 1; i < 4; i++) begin
      if (lvl[i] != '0 && lvl[i] < flr) flr = lvl[i];
    end
    acc = '0;
    for (i = 0; i < 4; i++) begin
      acc += light_sum_t'((lvl[i] < flr) ? flr : lvl[i]);
    end
    return acc;
  endfunction

  function automatic occ_t corner_shade(logic ea, logic eb, logic dg);
    if (ea && eb) return OCC_BOTH_EDGES;
    return OCC_OPEN - occ_t'(ea) - occ_t'(eb) - occ_t'(dg);
  endfunction

  function automatic corner_light_t predict_corners(light_t cb, light_t cs,
                                                    logic [NUM_CELLS-1:0] mask,
                                                    logic [NUM_CELLS*LB-1:0] nb,
                                                    logic [NUM_CELLS*LB-1:0] ns);
    corner_light_t r;
    int unsigned   k;
    int unsigned   a;
    int unsigned   b;
    int unsigned   d;
    for (k = 0; k < NUM_CORNERS; k++) begin
      a = CORNER_NBR[k][0];
      b = CORNER_NBR[k][1];
      d = CORNER_NBR[k][2];
      r.occ[k] = corner_shade(mask[a], mask[b], mask[d]);
      r.blk[k] = smoothed_sum(cb, nb[a*LB +: LB], nb[b*LB +: LB], nb[d*LB +: LB]);
      r.sky[k] = smoothed_sum(cs, ns[a*LB +: LB], ns[b*LB +: LB], ns[d*LB +: LB]);
    end
    return r;
  endfunction

  always @(posedge clk_i) begin : track
    corner_light_t want;
    corner_light_t got;
    int unsigned   k;
    if (rst_ni) begin
      // Results trail their face through the registered result stage: retire before adding.
      if (vtx_i.valid && vtx_i.ready) begin
        got.occ = {vtx_i.occlusion_corner3, vtx_i.occlusion_corner2,
                   vtx_i.occlusion_corner1, vtx_i.occlusion_corner0};
        got.blk = {vtx_i.block_sum_corner3, vtx_i.block_sum_corner2,
                   vtx_i.block_sum_corner1, vtx_i.block_sum_corner0};
        got.sky = {vtx_i.sky_sum_corner3, vtx_i.sky_sum_corner2,
                   vtx_i.sky_sum_corner1, vtx_i.sky_sum_corner0};
        if (corner_light_q.size() == 0) begin
          $error("result transfer with no face outstanding");
          errors++;
        end else begin
          want = corner_light_q.pop_front();
          for (k = 0; k < NUM_CORNERS; k++) begin
            if (got.occ[k] !== want.occ[k]) begin
              $error("occlusion_corner%0d: expected %0d, got %0d", k, want.occ[k], got.occ[k]);
              errors++;
            end
            if (got.blk[k] !== want.blk[k]) begin
              $error("block_sum_corner%0d: expected %0d, got %0d", k, want.blk[k], got.blk[k]);
              errors++;
            end
            if (got.sky[k] !== want.sky[k]) begin
              $error("sky_sum_corner%0d: expected %0d, got %0d", k, want.sky[k], got.sky[k]);
              errors++;
            end
          end
        end
      end
      if (face_i.valid && face_i.ready) begin
        corner_light_q.push_back(predict_corners(face_i.center_block_light,
                                                 face_i.center_sky_light,
                                                 face_i.neighbour_opaque_mask,
                                                 face_i.neighbour_block_lights,
                                                 face_i.neighbour_sky_lights));
      end
    end
    fail_cnt_o <= errors;
    pending_o  <= corner_light_q.size();
  end

endmodule

@@ verif/voxel_face_vertex_light_ao_tb.sv @@
// Top of the voxel_face_vertex_light_ao testbench: clock, reset, face stimulus, result
// back-pressure and the verdict. Checking lives in vfl_face_light_checker.
// Depends on vfl_pkg, vfl_intf, the block and the checker.
module voxel_face_vertex_light_ao_tb import vfl_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LB          = LIGHT_BITS_DEF;
  localparam int unsigned LIGHTS_W    = NUM_CELLS * LB;
  localparam int unsigned PHASES      = 8;
  localparam int unsigned PER_PHASE   = 200;
  localparam int unsigned HOLD_CYCLES = 150;
  localparam int unsigned CYCLE_LIMIT = 200000;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  int          fail_cnt;
  int          pending_faces;
  int unsigned cycle_cnt = 0;
  bit          calm = 1'b0;
  bit          hold_req = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  vfl_face_if   #(.LIGHT_BITS(LB)) face_if ();
  vfl_vertex_if #(.LIGHT_BITS(LB)) vtx_if ();

  voxel_face_vertex_light_ao #(.LIGHT_BITS(LB)) u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .face_i (face_if),
    .vtx_o  (vtx_if)
  );

  vfl_face_light_checker #(.LB(LB)) u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .face_i     (face_if),
    .vtx_i      (vtx_if),
    .fail_cnt_o (fail_cnt),
    .pending_o  (pending_faces)
  );

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Lean toward dark, full and dimmest levels so the floor logic gets exercised.
  function automatic logic [LB-1:0] draw_level();
    case ($urandom_range(0, 4))
      0: return '0;
      1: return '1;
      2: return LB'(1);
      default: return LB'($urandom_range(0, (1 << LB) - 1));
    endcase
  endfunction

  function automatic logic [LIGHTS_W-1:0] draw_levels();
    logic [LIGHTS_W-1:0] r;
    int unsigned         i;
    for (i = 0; i < NUM_CELLS; i++) r[i*LB +: LB] = draw_level();
    return r;
  endfunction

  function automatic int unsigned draw_wait();
    return calm ? 0 : $urandom_range(0, 6);
  endfunction

  task automatic send_face(input logic [LB-1:0] cb, input logic [LB-1:0] cs,
                           input logic [NUM_CELLS-1:0] mask,
                           input logic [LIGHTS_W-1:0] nb, input logic [LIGHTS_W-1:0] ns);
    int unsigned gap;
    gap = draw_wait();
    if (gap != 0) begin
      face_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    face_if.valid                  <= 1'b1;
    face_if.center_block_light     <= cb;
    face_if.center_sky_light       <= cs;
    face_if.neighbour_opaque_mask  <= mask;
    face_if.neighbour_block_lights <= nb;
    face_if.neighbour_sky_lights   <= ns;
    @(posedge clk_i);
    while (!face_if.ready) @(posedge clk_i);
  endtask

  // Stop offering faces and hold until every predicted result has been seen.
  task automatic drain_faces();
    face_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_faces != 0) @(posedge clk_i);
  endtask

  initial begin : stimulus
    int unsigned ph;
    int unsigned n;
    int unsigned i;
    rst_ni                          = 1'b0;
    face_if.valid                  <= 1'b0;
    face_if.center_block_light     <= '0;
    face_if.center_sky_light       <= '0;
    face_if.neighbour_opaque_mask  <= '0;
    face_if.neighbour_block_lights <= '0;
    face_if.neighbour_sky_lights   <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed faces: extremes, both-edge occlusion per corner, dark center,
    // all-dark neighbours, no dark value at all, mixed dark neighbours.
    send_face('0, '0, 8'h00, '0, '0);
    send_face('1, '1, 8'hFF, '1, '1);
    send_face(4'd7, 4'd0, 8'h0A, '0, '0);
    send_face(4'd0, 4'd9, 8'h48, '1, '0);
    send_face(4'd15, 4'd15, 8'h50, 32'h1111_1111, 32'h2222_2222);
    send_face(4'd15, 4'd3, 8'h12, 32'h0F0F_0F0F, 32'hF0F0_F0F0);
    send_face(4'd15, 4'd15, 8'h25, 32'h1010_1010, 32'h0101_0101);
    send_face(4'd5, 4'd12, 8'h5A, 32'h0000_0001, 32'h8000_0000);
    send_face(4'd1, 4'd2, 8'hA5, 32'h9ABC_DEF0, 32'h0FED_CBA9);
    send_face(4'd8, 4'd8, 8'hF0, 32'h3050_0207, 32'h0460_0300);
    send_face(4'd2, 4'd14, 8'h0F, 32'h0E0D_0C0B, 32'h0A09_0807);
    for (i = 0; i < NUM_CELLS; i++) begin
      send_face(draw_level(), draw_level(), NUM_CELLS'(1 << i), draw_levels(), draw_levels());
    end

    for (ph = 0; ph < PHASES; ph++) begin
      calm = (ph == 1 || ph == 5);
      if (ph == 3) hold_req = 1'b1;
      if (ph == 2 || ph == 6) drain_faces();
      for (n = 0; n < PER_PHASE; n++) begin
        send_face(draw_level(), draw_level(), NUM_CELLS'($urandom), draw_levels(),
                  draw_levels());
      end
    end
    calm = 1'b0;

    drain_faces();
    repeat (8) @(posedge clk_i);
    if (fail_cnt == 0 && pending_faces == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin : result_sink
    int unsigned stall;
    vtx_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if (hold_req) begin
        stall    = HOLD_CYCLES;
        hold_req = 1'b0;
      end else begin
        stall = draw_wait();
      end
      if (stall != 0) begin
        vtx_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      vtx_if.ready <= 1'b1;
      @(posedge clk_i);
      while (!vtx_if.valid) @(posedge clk_i);
    end
  end

endmodule

@@ sim.f @@
hdl/vfl_pkg.sv
hdl/vfl_intf.sv
hdl/vfl_lane.sv
hdl/vfl_merge.sv
hdl/voxel_face_vertex_light_ao.sv
verif/vfl_face_light_checker.sv
verif/voxel_face_vertex_light_ao_tb.sv
